FILE: hdl/mmss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmss_pkg
// Shared types and constants for the multi-mode server selector.
// ----------------------------------------------------------------------------
package mmss_pkg;

    localparam int DEF_MAX_SERVERS = 8;
    localparam int DEF_WEIGHT_BITS = 8;

    localparam int ID_W     = 4;
    localparam int TAG_W    = 16;
    localparam int WEIGHTS_W = 64;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        MODE_ROUND_ROBIN = 2'd0,
        MODE_SWEEP       = 2'd1,
        MODE_ODD_EVEN    = 2'd2,
        MODE_WEIGHTED    = 2'd3
    } sel_mode_t;

    typedef enum logic [1:0] {
        REG_MODE        = 2'd0,
        REG_NUM_SERVERS = 2'd1,
        REG_WEIGHTS     = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_index_t;

    // Selection state apart from the weighted use counter.
    typedef struct packed {
        logic [ID_W-1:0] pointer;
        logic            direction_down;
        logic [ID_W-1:0] odd_next;
        logic [ID_W-1:0] even_next;
    } sel_state_t;

    localparam sel_state_t STATE_RESET = '{
        pointer:        4'd1,
        direction_down: 1'b0,
        odd_next:       4'd1,
        even_next:      4'd2
    };

endpackage

FILE: hdl/mmss_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmss_pick
// Combinational server choice and next selection state for one word.
// ----------------------------------------------------------------------------
module mmss_pick #(
    parameter int MAX_SERVERS = mmss_pkg::DEF_MAX_SERVERS,
    parameter int WEIGHT_BITS = mmss_pkg::DEF_WEIGHT_BITS
) (
    input  mmss_pkg::sel_mode_t              mode,
    input  logic [mmss_pkg::ID_W-1:0]        num_servers,
    input  logic [mmss_pkg::WEIGHTS_W-1:0]   weights,
    input  mmss_pkg::sel_state_t             state_cur,
    input  logic [WEIGHT_BITS-1:0]           use_count_cur,
    output mmss_pkg::sel_state_t             state_new,
    output logic [WEIGHT_BITS-1:0]           use_count_new,
    output logic [mmss_pkg::ID_W-1:0]        server_id
);
    import mmss_pkg::*;

    logic [ID_W-1:0]        n;
    logic [ID_W-1:0]        p;
    logic [6:0]             off;
    logic [WEIGHTS_W-1:0]   wsh;
    logic [WEIGHT_BITS-1:0] w;
    logic [ID_W:0]          odd_plus;
    logic [ID_W:0]          even_plus;
    logic                   odd_ok;
    logic                   even_ok;

    // Servers in use, with out-of-range counts clamped.
    always_comb begin
        n = num_servers;
        if (n == '0) begin
            n = 4'd1;
        end
        if (5'(n) > 5'(MAX_SERVERS)) begin
            n = 4'(MAX_SERVERS);
        end
    end

    // Weight of the server under the pointer; fields past bit 63 read as zero.
    always_comb begin
        p = state_cur.pointer;
        if (p == '0 || p > n) begin
            p = 4'd1;
        end
        off = 7'(p - 4'd1) * 7'(WEIGHT_BITS);
        wsh = weights >> off;
        w   = wsh[WEIGHT_BITS-1:0];
    end

    assign odd_ok  = (state_cur.odd_next != '0) && (state_cur.odd_next <= n);
    assign even_ok = (state_cur.even_next != '0) && (state_cur.even_next <= n);

    always_comb begin
        state_new     = state_cur;
        use_count_new = use_count_cur;
        server_id     = '0;
        odd_plus      = '0;
        even_plus     = '0;
        case (mode)
            MODE_ROUND_ROBIN: begin
                server_id = p;
                state_new.pointer = (p >= n) ? 4'd1 : p + 4'd1;
            end
            MODE_SWEEP: begin
                if (n == 4'd1) begin
                    server_id = 4'd1;
                    state_new.pointer = 4'd1;
                    state_new.direction_down = 1'b0;
                end else begin
                    // A stale pointer is first brought back inside the sweep.
                    state_new.pointer = state_cur.pointer;
                    if (state_cur.pointer > n) begin
                        state_new.pointer = n - 4'd1;
                        state_new.direction_down = 1'b1;
                    end else if (state_cur.pointer == '0) begin
                        state_new.pointer = 4'd2;
                        state_new.direction_down = 1'b0;
                    end
                    server_id = state_new.pointer;
                    if (state_new.direction_down) begin
                        if (server_id <= 4'd1) begin
                            state_new.pointer = 4'd2;
                            state_new.direction_down = 1'b0;
                        end else begin
                            state_new.pointer = server_id - 4'd1;
                        end
                    end else begin
                        if (server_id >= n) begin
                            state_new.pointer = n - 4'd1;
                            state_new.direction_down = 1'b1;
                        end else begin
                            state_new.pointer = server_id + 4'd1;
                        end
                    end
                end
            end
            MODE_ODD_EVEN: begin
                if (odd_ok || !even_ok) begin
                    // Both lists exhausted restarts them and serves server 1.
                    server_id = odd_ok ? state_cur.odd_next : 4'd1;
                    if (!odd_ok) begin
                        state_new.even_next = 4'd2;
                    end
                    odd_plus = 5'(server_id) + 5'd2;
                    state_new.odd_next = (odd_plus > 5'(n)) ? 4'd0 : odd_plus[ID_W-1:0];
                end else begin
                    server_id = state_cur.even_next;
                    even_plus = 5'(server_id) + 5'd2;
                    state_new.even_next = (even_plus > 5'(n)) ? 4'd0 : even_plus[ID_W-1:0];
                end
            end
            MODE_WEIGHTED: begin
                state_new.pointer = p;
                if (use_count_cur < w) begin
                    server_id     = p;
                    use_count_new = use_count_cur + WEIGHT_BITS'(1);
                end
                if (use_count_new >= w) begin
                    use_count_new     = '0;
                    state_new.pointer = (p >= n) ? 4'd1 : p + 4'd1;
                end
            end
            default: begin
                server_id = '0;
            end
        endcase
    end

endmodule

FILE: hdl/multi_mode_server_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_mode_server_selector
// Assigns each request word to a server under a round robin, sweep,
// odd/even or weighted policy; the tag and last flag pass through.
// ----------------------------------------------------------------------------
// The result word appears on m_tdata in the cycle after input acceptance.
// Throughput: one word per cycle while m_tready allows; the selection update is combinational.
// The output register frees itself in the same cycle the result is taken.
// Reset (aresetn low, synchronous) clears the output valid, the selection
// state and the registers (mode 0, one server, all weights zero).
// ----------------------------------------------------------------------------
module multi_mode_server_selector #(
    parameter int MAX_SERVERS = mmss_pkg::DEF_MAX_SERVERS,
    parameter int WEIGHT_BITS = mmss_pkg::DEF_WEIGHT_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [1:0]                          cfg_index,
    input  logic [mmss_pkg::WEIGHTS_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mmss_pkg::IN_DATA_W-1:0]      s_tdata,   // [15:0] request_tag
    input  logic                                s_tlast,   // last_request
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mmss_pkg::OUT_DATA_W-1:0]     m_tdata,   // [3:0] server_id, [19:4] tag_out
    output logic                                m_tlast    // last_out
);
    import mmss_pkg::*;

    sel_mode_t              mode_reg;
    logic [ID_W-1:0]        num_servers_reg;
    logic [WEIGHTS_W-1:0]   weights_reg;

    sel_state_t             st_reg;
    sel_state_t             st_next;
    logic [WEIGHT_BITS-1:0] use_count_reg;
    logic [WEIGHT_BITS-1:0] use_count_next;
    logic [ID_W-1:0]        pick_id;

    logic                   out_valid_reg;
    logic [ID_W-1:0]        out_id_reg;
    logic [TAG_W-1:0]       out_tag_reg;
    logic                   out_last_reg;
    logic                   accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_ROUND_ROBIN;
            num_servers_reg <= 4'd1;
            weights_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_index))
                REG_MODE:        mode_reg        <= sel_mode_t'(cfg_wdata[1:0]);
                REG_NUM_SERVERS: num_servers_reg <= cfg_wdata[ID_W-1:0];
                REG_WEIGHTS:     weights_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    mmss_pick #(
        .MAX_SERVERS (MAX_SERVERS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_pick (
        .mode          (mode_reg),
        .num_servers   (num_servers_reg),
        .weights       (weights_reg),
        .state_cur     (st_reg),
        .use_count_cur (use_count_reg),
        .state_new     (st_next),
        .use_count_new (use_count_next),
        .server_id     (pick_id)
    );

    // A word flagged last closes the batch and returns the state to reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= STATE_RESET;
            use_count_reg <= '0;
        end else if (accept) begin
            if (s_tlast) begin
                st_reg        <= STATE_RESET;
                use_count_reg <= '0;
            end else begin
                st_reg        <= st_next;
                use_count_reg <= use_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_id_reg   <= pick_id;
            out_tag_reg  <= s_tdata[TAG_W-1:0];
            out_last_reg <= s_tlast;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_tag_reg, out_id_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (st_reg == STATE_RESET && use_count_reg == '0))
        else $error("state not cleared after last word");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> ($stable(st_reg) && $stable(use_count_reg)))
        else $error("selection state changed without an accepted word");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (out_valid_reg && out_tag_reg == $past(s_tdata[TAG_W-1:0])))
        else $error("accepted word did not reach the output register");

    a_id_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (5'(out_id_reg) <= 5'(MAX_SERVERS)))
        else $error("server id beyond the server count");
`endif

endmodule

FILE: verif/multi_mode_server_selector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_mode_server_selector_tb
// Self-checking bench for the server selector. Sends request words under
// every policy and a range of register settings, with random gaps on both
// streams, and checks each result word against a cycle-free selection model.
// ----------------------------------------------------------------------------
module multi_mode_server_selector_tb;
    import mmss_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int REQUEST_TARGET = 2025;
    localparam int STEADY_SPAN    = 400;
    localparam int MAX_SRV        = DEF_MAX_SERVERS;
    localparam int WBITS          = DEF_WEIGHT_BITS;

    typedef struct {
        logic [ID_W-1:0]  server_id;
        logic [TAG_W-1:0] tag;
        logic             last;
    } assignment_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [1:0]            cfg_index;
    logic [WEIGHTS_W-1:0]  cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // [15:0] request_tag
    logic                  s_tlast;   // last_request
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;   // [3:0] server_id, [19:4] tag_out
    logic                  m_tlast;   // last_out

    // Selection model: register copies and selection state.
    sel_mode_t             cur_mode;
    logic [3:0]            cur_servers;
    logic [WEIGHTS_W-1:0]  cur_weights;
    sel_state_t            sel_st;
    logic [7:0]            use_count;

    assignment_t pending_assignments[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          requests_sent = 0;
    bit          steady_flow = 1'b0;

    multi_mode_server_selector u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int weight_of(int k);
        int off;
        off = (k - 1) * WBITS;
        if (off >= WEIGHTS_W) return 0;
        return int'((cur_weights >> off) & ((64'd1 << WBITS) - 64'd1));
    endfunction

    // Works out the server for one request and advances the selection state.
    function automatic logic [ID_W-1:0] choose_server();
        int  n;
        int  p;
        int  w;
        int  id;
        int  odd_v;
        int  even_v;
        bit  odd_ok;
        bit  even_ok;
        n = int'(cur_servers);
        if (n < 1) n = 1;
        if (n > MAX_SRV) n = MAX_SRV;
        p = int'(sel_st.pointer);
        id = 0;
        case (cur_mode)
            MODE_ROUND_ROBIN: begin
                if (p < 1 || p > n) p = 1;
                id = p;
                p++;
                if (p > n) p = 1;
                sel_st.pointer = 4'(p);
            end
            MODE_SWEEP: begin
                if (n == 1) begin
                    sel_st.pointer = 4'd1;
                    sel_st.direction_down = 1'b0;
                    id = 1;
                end else begin
                    if (p > n) begin
                        p = n - 1;
                        sel_st.direction_down = 1'b1;
                    end else if (p < 1) begin
                        p = 2;
                        sel_st.direction_down = 1'b0;
                    end
                    id = p;
                    if (sel_st.direction_down) begin
                        if (p <= 1) begin
                            p = 2;
                            sel_st.direction_down = 1'b0;
                        end else begin
                            p--;
                        end
                    end else begin
                        if (p >= n) begin
                            p = n - 1;
                            sel_st.direction_down = 1'b1;
                        end else begin
                            p++;
                        end
                    end
                    sel_st.pointer = 4'(p);
                end
            end
            MODE_ODD_EVEN: begin
                odd_v = int'(sel_st.odd_next);
                even_v = int'(sel_st.even_next);
                odd_ok = odd_v >= 1 && odd_v <= n;
                even_ok = even_v >= 1 && even_v <= n;
                // With both halves used up the sweep starts over at server 1.
                if (!odd_ok && !even_ok) begin
                    odd_v = 1;
                    even_v = 2;
                    odd_ok = 1'b1;
                end
                if (odd_ok) begin
                    id = odd_v;
                    odd_v = (odd_v + 2 > n) ? 0 : odd_v + 2;
                end else begin
                    id = even_v;
                    even_v = (even_v + 2 > n) ? 0 : even_v + 2;
                end
                sel_st.odd_next = 4'(odd_v);
                sel_st.even_next = 4'(even_v);
            end
            default: begin
                if (p < 1 || p > n) p = 1;
                w = weight_of(p);
                if (int'(use_count) < w) begin
                    id = p;
                    use_count++;
                end
                if (int'(use_count) >= w) begin
                    use_count = '0;
                    p++;
                    if (p > n) p = 1;
                end
                sel_st.pointer = 4'(p);
            end
        endcase
        return 4'(id);
    endfunction

    // Model update and result check, both at the clock edge.
    always @(posedge aclk) begin
        assignment_t exp_a;
        assignment_t act_a;
        if (!aresetn) begin
            cur_mode = MODE_ROUND_ROBIN;
            cur_servers = 4'd1;
            cur_weights = '0;
            sel_st = STATE_RESET;
            use_count = '0;
            pending_assignments.delete();
        end else begin
            if (cfg_wr_en) begin
                case (reg_index_t'(cfg_index))
                    REG_MODE:        cur_mode = sel_mode_t'(cfg_wdata[1:0]);
                    REG_NUM_SERVERS: cur_servers = cfg_wdata[3:0];
                    REG_WEIGHTS:     cur_weights = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                exp_a.server_id = choose_server();
                exp_a.tag = s_tdata[TAG_W-1:0];
                exp_a.last = s_tlast;
                pending_assignments = {pending_assignments, exp_a};
                if (s_tlast) begin
                    sel_st = STATE_RESET;
                    use_count = '0;
                end
            end
            if (m_tvalid && m_tready) begin
                act_a.server_id = m_tdata[ID_W-1:0];
                act_a.tag = m_tdata[ID_W +: TAG_W];
                act_a.last = m_tlast;
                if (pending_assignments.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] unexpected result word: id=%0d tag=%h last=%b",
                                 $realtime, act_a.server_id, act_a.tag, act_a.last);
                end else begin
                    exp_a = pending_assignments.pop_front();
                    if (act_a.server_id !== exp_a.server_id || act_a.tag !== exp_a.tag ||
                        act_a.last !== exp_a.last ||
                        m_tdata[OUT_DATA_W-1:ID_W+TAG_W] !== '0) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"[%0t] mismatch: expected id=%0d tag=%h last=%b, ",
                                      "got id=%0d tag=%h last=%b pad=%h"},
                                     $realtime, exp_a.server_id, exp_a.tag, exp_a.last,
                                     act_a.server_id, act_a.tag, act_a.last,
                                     m_tdata[OUT_DATA_W-1:ID_W+TAG_W]);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= steady_flow || ($urandom_range(0, 99) >= 8);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic write_reg(reg_index_t idx, logic [WEIGHTS_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_request(logic [TAG_W-1:0] tag, logic last);
        while (!steady_flow && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= tag;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    // Lets every outstanding word come back so registers can change safely.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_assignments.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic test_reset_state();
        send_request(16'h0000, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'hA5A5, 1'b1);
        drain();
    endtask

    task automatic test_round_robin();
        write_reg(REG_MODE, 64'(MODE_ROUND_ROBIN));
        write_reg(REG_NUM_SERVERS, 64'd3);
        for (int i = 0; i < 4; i++) send_request(16'(16'h5A00 + i), i == 3);
        drain();
    endtask

    task automatic test_sweep();
        write_reg(REG_MODE, 64'(MODE_SWEEP));
        for (int i = 0; i < 5; i++) send_request(16'(16'h1230 + i), i == 4);
        drain();
        // A single server must always be picked, whatever the pointer says.
        write_reg(REG_NUM_SERVERS, 64'd1);
        send_request(16'h3C3C, 1'b1);
        drain();
    endtask

    task automatic test_odd_even();
        write_reg(REG_MODE, 64'(MODE_ODD_EVEN));
        write_reg(REG_NUM_SERVERS, 64'd3);
        for (int i = 0; i < 4; i++) send_request(16'(16'hC0DE + i), i == 3);
        drain();
    endtask

    task automatic test_weighted();
        write_reg(REG_MODE, 64'(MODE_WEIGHTED));
        write_reg(REG_WEIGHTS, 64'h0002_0003);
        send_request(16'h0101, 1'b0);
        send_request(16'h0202, 1'b0);
        drain();
        // Server 1 already used twice; dropping its weight to one leaves the
        // next word unassigned, then the zero-weight server does the same.
        write_reg(REG_WEIGHTS, 64'h0002_0001);
        send_request(16'h0303, 1'b0);
        send_request(16'h0404, 1'b0);
        send_request(16'h0505, 1'b1);
        drain();
    endtask

    task automatic test_register_edges();
        write_reg(REG_MODE, 64'hFFFF_FFFF_FFFF_FFFC);
        write_reg(REG_NUM_SERVERS, 64'd0);
        send_request(16'h8001, 1'b0);
        drain();
        write_reg(REG_NUM_SERVERS, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(16'h7FFE, 1'b0);
        send_request(16'h0F0F, 1'b0);
        drain();
        write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_MODE, 64'(MODE_WEIGHTED));
        write_reg(REG_WEIGHTS, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_NUM_SERVERS, 64'd8);
        send_request(16'hF0F0, 1'b0);
        send_request(16'h5555, 1'b1);
        drain();
    endtask

    task automatic pick_random_settings();
        logic [WEIGHTS_W-1:0] w;
        int                   r;
        if ($urandom_range(0, 9) < 7)
            write_reg(REG_MODE, {$urandom, $urandom} & ~64'd3 | 64'($urandom_range(0, 3)));
        if ($urandom_range(0, 9) < 7) begin
            r = $urandom_range(0, 9);
            if (r < 8)
                write_reg(REG_NUM_SERVERS, 64'($urandom_range(1, MAX_SRV)));
            else if (r == 8)
                write_reg(REG_NUM_SERVERS, {$urandom, $urandom} & ~64'hF);
            else
                write_reg(REG_NUM_SERVERS, 64'($urandom_range(MAX_SRV + 1, 15)));
        end
        if ($urandom_range(0, 9) < 6) begin
            for (int k = 0; k < WEIGHTS_W / 8; k++) begin
                r = $urandom_range(0, 9);
                if (r < 7)
                    w[k*8 +: 8] = 8'($urandom_range(0, 4));
                else if (r < 9)
                    w[k*8 +: 8] = 8'd0;
                else
                    w[k*8 +: 8] = 8'($urandom_range(0, 255));
            end
            write_reg(REG_WEIGHTS, w);
        end
        if ($urandom_range(0, 9) == 0)
            write_reg(REG_UNUSED, {$urandom, $urandom});
    endtask

    // Batches under changing settings; a batch without a closing last word
    // carries its selection state into the next setting.
    task automatic test_random_traffic();
        int len;
        bit close_batch;
        while (requests_sent < REQUEST_TARGET) begin
            steady_flow <= (requests_sent < STEADY_SPAN + 30);
            pick_random_settings();
            len = $urandom_range(5, 60);
            close_batch = $urandom_range(0, 2) != 0;
            for (int i = 0; i < len; i++)
                send_request(16'($urandom_range(0, 16'hFFFF)),
                             ($urandom_range(0, 19) == 0) || (close_batch && i == len - 1));
            drain();
        end
        steady_flow <= 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_MODE;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_round_robin();
        test_sweep();
        test_odd_even();
        test_weighted();
        test_register_edges();
        test_random_traffic();

        while (pending_assignments.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (mismatch_count == 0 && pending_assignments.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
